[src/ihex_pkg.sv]
// Shared types, constants and helpers for the Intel HEX data extractor.
// Used by intel_hex_data_extractor; has no dependencies of its own.
package ihex_pkg;

  // image capacity in bytes and derived widths
  localparam int unsigned IMAGE_BYTES = 131072;
  localparam int unsigned IDX_W       = $clog2(IMAGE_BYTES);
  localparam int unsigned POS_W       = IDX_W + 1;

  // stream widths
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OUT_FIELD_W = BYTE_W + IDX_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_MARK    = 8'h3A;

  // last digit index within the two-digit and four-digit fields
  localparam logic [1:0] LAST_PAIR_DIGIT = 2'd1;
  localparam logic [1:0] LAST_ADDR_DIGIT = 2'd3;

  // full-image position and the index reported for dropped bytes
  localparam logic [POS_W-1:0] POS_FULL  = POS_W'(IMAGE_BYTES);
  localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(IMAGE_BYTES - 1);

  // line parser phases
  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SKIP,
    PH_COUNT,
    PH_ADDR,
    PH_KIND,
    PH_DATA
  } phase_t;

  // hex digit value, anything else decodes as its low four bits
  function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [3:0] n;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n = c[3:0] + 4'd9;
    end else begin
      n = c[3:0];
    end
    return n;
  endfunction

endpackage

[src/intel_hex_data_extractor.sv]
// Top level of the Intel HEX data extractor: line parser and output register.
// Depends on ihex_pkg for types, constants and the digit decoder.
//
// Takes one ASCII character per beat and returns one beat per decoded data
// byte of a type 0 record, carrying the byte, its position in a packed image
// that grows across records, and an overflow flag once the image holds
// ihex_pkg::IMAGE_BYTES bytes (the index then stays at the last position).
// Every character is parsed in the cycle it is taken, so the block takes one
// character per cycle; the single output register is refilled in the same
// cycle it is drained, and only a stalled output with a pending result holds
// the input off. A result is registered when the second digit of its byte is
// taken. Address and checksum digits are not checked; a newline ends the
// current line at any point.
module intel_hex_data_extractor (
  input  logic                              clk,
  input  logic                              rst_n,
  // character input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ihex_pkg::CHAR_W-1:0]       in_tdata,   // [7:0] char_in
  // decoded byte output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ihex_pkg::OUT_DATA_W-1:0]   out_tdata,  // [7:0] data_byte, [24:8] byte_index
  output logic                              out_tuser   // [0] overflow
);

  ihex_pkg::phase_t                phase_r, phase_nxt;
  logic [1:0]                      digit_cnt_r, digit_cnt_nxt;
  logic [7:0]                      rec_len_r, rec_len_nxt;
  logic [7:0]                      rec_kind_r, rec_kind_nxt;
  logic [7:0]                      bytes_left_r, bytes_left_nxt;
  logic [3:0]                      high_nib_r, high_nib_nxt;
  logic [ihex_pkg::POS_W-1:0]      wr_pos_r, wr_pos_nxt;

  logic                            out_valid_r;
  logic [ihex_pkg::BYTE_W-1:0]     data_byte_r, data_byte_nxt;
  logic [ihex_pkg::IDX_W-1:0]      byte_index_r, byte_index_nxt;
  logic                            overflow_r, overflow_nxt;

  logic                            in_fire;
  logic                            is_newline;
  logic [3:0]                      nib;
  logic [7:0]                      kind_shift;
  logic                            emit;

  // input handshake: take a beat unless a result is stuck in the output register
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign is_newline = (in_tdata == ihex_pkg::CH_NEWLINE);
  assign nib        = ihex_pkg::nibble_of(in_tdata);
  assign kind_shift = {rec_kind_r[3:0], nib};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_newline) begin
      phase_nxt = ihex_pkg::PH_LINE_START;
    end else begin
      unique case (phase_r)
        ihex_pkg::PH_LINE_START: begin
          phase_nxt = (in_tdata == ihex_pkg::CH_MARK) ? ihex_pkg::PH_COUNT
                                                      : ihex_pkg::PH_SKIP;
        end
        ihex_pkg::PH_COUNT: begin
          if (digit_cnt_r == ihex_pkg::LAST_PAIR_DIGIT) phase_nxt = ihex_pkg::PH_ADDR;
        end
        ihex_pkg::PH_ADDR: begin
          if (digit_cnt_r == ihex_pkg::LAST_ADDR_DIGIT) phase_nxt = ihex_pkg::PH_KIND;
        end
        ihex_pkg::PH_KIND: begin
          if (digit_cnt_r == ihex_pkg::LAST_PAIR_DIGIT) begin
            phase_nxt = (kind_shift == 8'd0 && rec_len_r != 8'd0) ? ihex_pkg::PH_DATA
                                                                  : ihex_pkg::PH_SKIP;
          end
        end
        ihex_pkg::PH_DATA: begin
          if (digit_cnt_r == ihex_pkg::LAST_PAIR_DIGIT && bytes_left_r == 8'd1) begin
            phase_nxt = ihex_pkg::PH_SKIP;
          end
        end
        ihex_pkg::PH_SKIP: phase_nxt = ihex_pkg::PH_SKIP;
        default:           phase_nxt = ihex_pkg::PH_LINE_START;
      endcase
    end
  end

  // field counters, record fields and result
  always_comb begin
    digit_cnt_nxt  = digit_cnt_r;
    rec_len_nxt    = rec_len_r;
    rec_kind_nxt   = rec_kind_r;
    bytes_left_nxt = bytes_left_r;
    high_nib_nxt   = high_nib_r;
    wr_pos_nxt     = wr_pos_r;
    emit           = 1'b0;
    data_byte_nxt  = {high_nib_r, nib};
    byte_index_nxt = wr_pos_r[ihex_pkg::IDX_W-1:0];
    overflow_nxt   = 1'b0;
    if (is_newline) begin
      digit_cnt_nxt = 2'd0;
    end else begin
      unique case (phase_r)
        ihex_pkg::PH_LINE_START: begin
          if (in_tdata == ihex_pkg::CH_MARK) begin
            digit_cnt_nxt = 2'd0;
            rec_len_nxt   = 8'd0;
          end
        end
        ihex_pkg::PH_COUNT: begin
          rec_len_nxt   = {rec_len_r[3:0], nib};
          digit_cnt_nxt = (digit_cnt_r == ihex_pkg::LAST_PAIR_DIGIT) ? 2'd0 : 2'd1;
        end
        ihex_pkg::PH_ADDR: begin
          if (digit_cnt_r == ihex_pkg::LAST_ADDR_DIGIT) begin
            digit_cnt_nxt = 2'd0;
            rec_kind_nxt  = 8'd0;
          end else begin
            digit_cnt_nxt = digit_cnt_r + 2'd1;
          end
        end
        ihex_pkg::PH_KIND: begin
          rec_kind_nxt = kind_shift;
          if (digit_cnt_r == ihex_pkg::LAST_PAIR_DIGIT) begin
            digit_cnt_nxt = 2'd0;
            if (kind_shift == 8'd0 && rec_len_r != 8'd0) bytes_left_nxt = rec_len_r;
          end else begin
            digit_cnt_nxt = 2'd1;
          end
        end
        ihex_pkg::PH_DATA: begin
          if (digit_cnt_r == 2'd0) begin
            high_nib_nxt  = nib;
            digit_cnt_nxt = 2'd1;
          end else begin
            digit_cnt_nxt  = 2'd0;
            emit           = 1'b1;
            bytes_left_nxt = bytes_left_r - 8'd1;
            if (wr_pos_r != ihex_pkg::POS_FULL) begin
              wr_pos_nxt = wr_pos_r + 1'b1;
            end else begin
              byte_index_nxt = ihex_pkg::IDX_FULL;
              overflow_nxt   = 1'b1;
            end
          end
        end
        ihex_pkg::PH_SKIP: ;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ihex_pkg::PH_LINE_START;
      digit_cnt_r  <= 2'd0;
      rec_len_r    <= 8'd0;
      rec_kind_r   <= 8'd0;
      bytes_left_r <= 8'd0;
      high_nib_r   <= 4'd0;
      wr_pos_r     <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      rec_len_r    <= rec_len_nxt;
      rec_kind_r   <= rec_kind_nxt;
      bytes_left_r <= bytes_left_nxt;
      high_nib_r   <= high_nib_nxt;
      wr_pos_r     <= wr_pos_nxt;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      data_byte_r  <= data_byte_nxt;
      byte_index_r <= byte_index_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ihex_pkg::OUT_DATA_W - ihex_pkg::OUT_FIELD_W){1'b0}},
                       byte_index_r, data_byte_r};
  assign out_tuser  = overflow_r;

endmodule

[test/testbench.sv]
// Self-checking testbench for intel_hex_data_extractor: character stream in,
// decoded data bytes out, checked against a behavioral copy of the line parser.
// Depends on ihex_pkg and intel_hex_data_extractor.
`timescale 1ns / 100ps

module testbench;

  // characters and record types used by the stimulus
  localparam logic [ihex_pkg::CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [ihex_pkg::CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [7:0]                  REC_DATA     = 8'h00;
  localparam logic [7:0]                  REC_EOF      = 8'h01;
  localparam logic [7:0]                  REC_EXT_ADDR = 8'h04;
  localparam int                          RANDOM_CHARS = 1500;

  // one decoded byte as the block should report it
  typedef struct packed {
    logic [ihex_pkg::BYTE_W-1:0] value;
    logic [ihex_pkg::IDX_W-1:0]  index;
    logic                        dropped;
  } decoded_byte_t;

  // tracks the parser state and the image fill level, holds bytes still owed
  class hex_image_tracker;
    ihex_pkg::phase_t            ph;
    logic [1:0]                  digits;
    logic [7:0]                  rec_len;
    logic [7:0]                  rec_kind;
    logic [7:0]                  bytes_to_go;
    logic [3:0]                  hi;
    logic [ihex_pkg::POS_W-1:0]  fill;
    decoded_byte_t               owed_bytes[$];
    int                          errors;
    int                          chars_taken;
    int                          bytes_checked;
    int                          dropped_checked;

    function new();
      ph = ihex_pkg::PH_LINE_START;
      digits = '0;
      rec_len = '0;
      rec_kind = '0;
      bytes_to_go = '0;
      hi = '0;
      fill = '0;
      errors = 0;
      chars_taken = 0;
      bytes_checked = 0;
      dropped_checked = 0;
    endfunction

    // hex digit value; any other character counts as its low four bits
    function logic [3:0] digit_value(input logic [ihex_pkg::CHAR_W-1:0] c);
      logic [7:0] t;
      if (c >= "0" && c <= "9") begin
        t = c - "0";
      end else if (c >= "a" && c <= "f") begin
        t = c - "a" + 8'd10;
      end else if (c >= "A" && c <= "F") begin
        t = c - "A" + 8'd10;
      end else begin
        t = {4'h0, c[3:0]};
      end
      return t[3:0];
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction

    // advance the parser by one accepted character
    function void take_char(input logic [ihex_pkg::CHAR_W-1:0] c);
      logic [3:0]    nib;
      decoded_byte_t e;
      chars_taken++;
      if (c == ihex_pkg::CH_NEWLINE) begin
        ph = ihex_pkg::PH_LINE_START;
        digits = '0;
        return;
      end
      nib = digit_value(c);
      case (ph)
        ihex_pkg::PH_LINE_START: begin
          if (c == ihex_pkg::CH_MARK) begin
            ph = ihex_pkg::PH_COUNT;
            digits = '0;
            rec_len = '0;
          end else begin
            ph = ihex_pkg::PH_SKIP;
          end
        end
        ihex_pkg::PH_COUNT: begin
          rec_len = {rec_len[3:0], nib};
          if (digits == ihex_pkg::LAST_PAIR_DIGIT) begin
            digits = '0;
            ph = ihex_pkg::PH_ADDR;
          end else begin
            digits = ihex_pkg::LAST_PAIR_DIGIT;
          end
        end
        ihex_pkg::PH_ADDR: begin
          if (digits == ihex_pkg::LAST_ADDR_DIGIT) begin
            digits = '0;
            rec_kind = '0;
            ph = ihex_pkg::PH_KIND;
          end else begin
            digits = digits + 2'd1;
          end
        end
        ihex_pkg::PH_KIND: begin
          rec_kind = {rec_kind[3:0], nib};
          if (digits == ihex_pkg::LAST_PAIR_DIGIT) begin
            digits = '0;
            if (rec_kind == REC_DATA && rec_len != 8'd0) begin
              bytes_to_go = rec_len;
              ph = ihex_pkg::PH_DATA;
            end else begin
              ph = ihex_pkg::PH_SKIP;
            end
          end else begin
            digits = ihex_pkg::LAST_PAIR_DIGIT;
          end
        end
        ihex_pkg::PH_DATA: begin
          if (digits == 2'd0) begin
            hi = nib;
            digits = ihex_pkg::LAST_PAIR_DIGIT;
          end else begin
            digits = '0;
            e.value = {hi, nib};
            // image full: index parks at the last slot and the byte is dropped
            if (fill < ihex_pkg::POS_FULL) begin
              e.index = fill[ihex_pkg::IDX_W-1:0];
              e.dropped = 1'b0;
              fill = fill + 1'b1;
            end else begin
              e.index = ihex_pkg::IDX_FULL;
              e.dropped = 1'b1;
            end
            owed_bytes.push_back(e);
            bytes_to_go = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'd0) begin
              ph = ihex_pkg::PH_SKIP;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // compare one output beat with the oldest owed byte
    function void check_beat(input logic [ihex_pkg::OUT_DATA_W-1:0] tdata,
                             input logic tuser);
      decoded_byte_t e;
      bytes_checked++;
      if (tuser === 1'b1) begin
        dropped_checked++;
      end
      if (owed_bytes.size() == 0) begin
        $error("unexpected beat: data_byte %02h byte_index %0d overflow %b",
               tdata[ihex_pkg::BYTE_W-1:0], tdata[ihex_pkg::BYTE_W +: ihex_pkg::IDX_W],
               tuser);
        errors++;
        return;
      end
      e = owed_bytes.pop_front();
      if (tdata[ihex_pkg::BYTE_W-1:0] !== e.value) begin
        $error("data_byte: expected %02h, got %02h", e.value, tdata[ihex_pkg::BYTE_W-1:0]);
        errors++;
      end
      if (tdata[ihex_pkg::BYTE_W +: ihex_pkg::IDX_W] !== e.index) begin
        $error("byte_index: expected %0d, got %0d", e.index,
               tdata[ihex_pkg::BYTE_W +: ihex_pkg::IDX_W]);
        errors++;
      end
      if (tuser !== e.dropped) begin
        $error("overflow: expected %b, got %b", e.dropped, tuser);
        errors++;
      end
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [ihex_pkg::CHAR_W-1:0]     in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ihex_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  hex_image_tracker image;
  int               burst_left = 0;
  bit               idle_on    = 1'b1;
  int               chars_sent = 0;

  intel_hex_data_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // beat monitor: results first, since a result never belongs to the same edge's input
  always @(posedge clk) begin
    if (rst_n && image != null) begin
      if (out_tvalid && out_tready) begin
        image.check_beat(out_tdata, out_tuser);
      end
      if (in_tvalid && in_tready) begin
        image.take_char(in_tdata);
      end
    end
  end

  // receiver: short stalls between ready runs, now and then a long free stretch
  bit rx_ready_now = 1'b0;
  int rx_run       = 0;
  always @(negedge clk) begin
    if (rx_run == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        rx_ready_now = 1'b1;
        rx_run = $urandom_range(50, 300);
      end else if (rx_ready_now) begin
        rx_ready_now = 1'b0;
        rx_run = $urandom_range(1, 6);
      end else begin
        rx_ready_now = 1'b1;
        rx_run = $urandom_range(1, 16);
      end
    end else begin
      rx_run--;
    end
    out_tready <= rx_ready_now;
  end

  // one character beat; bursts of random length with random gaps between them
  task automatic send_char(input logic [ihex_pkg::CHAR_W-1:0] c);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = 0;
      if (idle_on) begin
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    chars_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  // hold the input off until every owed byte has come out or the limit runs out
  task automatic settle(input int limit);
    int w;
    @(negedge clk);
    in_tvalid <= 1'b0;
    for (w = 0; w < limit && image.pending() != 0; w++) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [ihex_pkg::CHAR_W-1:0] any_char();
    logic [ihex_pkg::CHAR_W-1:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CH_NEWLINE);
    return c;
  endfunction

  // hex digit in random case
  function automatic logic [ihex_pkg::CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return "0" + nib;
    end
    return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
  endfunction

  task automatic send_digit(input logic [3:0] nib, input bit noisy);
    if (noisy && $urandom_range(0, 7) == 0) begin
      send_char(any_char());
    end else begin
      send_char(hex_char(nib));
    end
  endtask

  task automatic send_pair(input logic [7:0] v, input bit noisy);
    send_digit(v[7:4], noisy);
    send_digit(v[3:0], noisy);
  endtask

  // one record line; data_digits may fall short of or run past the byte count
  task automatic send_record(input logic [7:0] len, input logic [7:0] kind,
                             input int data_digits, input bit noisy, input bit tail);
    int i;
    send_char(ihex_pkg::CH_MARK);
    send_pair(len, noisy);
    send_pair(8'($urandom_range(0, 255)), noisy);
    send_pair(8'($urandom_range(0, 255)), noisy);
    send_pair(kind, noisy);
    for (i = 0; i < data_digits; i++) begin
      send_digit(4'($urandom_range(0, 15)), noisy);
    end
    if (tail) begin
      send_pair(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        send_char(CH_CR);
      end
    end
    send_char(ihex_pkg::CH_NEWLINE);
  endtask

  // one random line: mostly records, the rest cut headers, junk and empty lines
  task automatic random_line();
    int         pick;
    int         r;
    int         i;
    int         n;
    logic [7:0] len;
    logic [7:0] kind;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    idle_on = ($urandom_range(0, 5) != 0);
    if (pick < 70) begin
      r = $urandom_range(0, 99);
      len = (r < 2) ? 8'hFF : (r < 8) ? 8'h00 : 8'($urandom_range(1, 24));
      r = $urandom_range(0, 99);
      if (r < 80) begin
        kind = REC_DATA;
      end else if (r < 87) begin
        kind = REC_EOF;
      end else if (r < 93) begin
        kind = REC_EXT_ADDR;
      end else begin
        kind = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        n = 2 * len;
      end else if (r < 90) begin
        n = $urandom_range(0, 2 * len);
      end else begin
        n = 2 * len + $urandom_range(1, 6);
      end
      send_record(len, kind, n, $urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0);
    end else if (pick < 80) begin
      // record cut inside or right after its header
      send_char(ihex_pkg::CH_MARK);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) begin
        send_digit(4'($urandom_range(0, 15)), 1'b1);
      end
      send_char(ihex_pkg::CH_NEWLINE);
    end else if (pick < 90) begin
      // line that is not a record
      do c = any_char(); while (c == ihex_pkg::CH_MARK);
      send_char(c);
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) begin
        send_char(any_char());
      end
      send_char(ihex_pkg::CH_NEWLINE);
    end else if (pick < 95) begin
      send_char(ihex_pkg::CH_NEWLINE);
    end else begin
      // raw bytes, newlines and colons included
      n = $urandom_range(1, 20);
      for (i = 0; i < n; i++) begin
        send_char(8'($urandom_range(0, 255)));
      end
      send_char(ihex_pkg::CH_NEWLINE);
    end
  endtask

  // main sequence
  initial begin
    int  target;
    bit  paused;
    image = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty line, junk line with 0xFF, extreme bytes in mixed case,
    // newline inside the byte count, NUL/CR/colon decoded as digits
    send_char(ihex_pkg::CH_NEWLINE);
    send_char(8'hFF);
    send_char(ihex_pkg::CH_NEWLINE);
    send_text(":0200000000fFFE");
    send_char(ihex_pkg::CH_NEWLINE);
    send_text(":0");
    send_char(ihex_pkg::CH_NEWLINE);
    send_text(":0100000");
    send_char(CH_NUL);
    send_char(CH_CR);
    send_char(ihex_pkg::CH_MARK);
    send_char(ihex_pkg::CH_NEWLINE);
    settle(1000);

    // random lines, with one full pause halfway
    target = chars_sent + RANDOM_CHARS;
    paused = 1'b0;
    while (chars_sent < target) begin
      random_line();
      if (!paused && chars_sent > target - RANDOM_CHARS / 2) begin
        paused = 1'b1;
        settle(5000);
      end
    end

    settle(5000);
    repeat (8) @(posedge clk);
    if (image.pending() != 0) begin
      $error("%0d decoded bytes never came out", image.pending());
      image.errors++;
    end

    $display("covered %0d characters and %0d decoded bytes, %0d dropped past capacity",
             image.chars_taken, image.bytes_checked, image.dropped_checked);
    $display("image filled to %0d bytes, %0d mismatches", image.fill, image.errors);
    if (image.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d decoded bytes outstanding", image.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
